[rtl/fsc_pkg.sv]
package fsc_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_TEST  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW,
      ST_SQR,
      ST_ROOT,
      ST_DIV,
      ST_TEST,
      ST_DONE
   } state_type;

   localparam int NUM_PLANES = 6;
   localparam int ROOT_BITS  = 50;

endpackage

[rtl/fsc_front.sv]
module fsc_front #(
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_opcode,
   input  logic [3:0]            in_index,
   input  logic [31:0]           in_value,
   input  logic [31:0]           in_cx,
   input  logic [31:0]           in_cy,
   input  logic [31:0]           in_cz,
   input  logic [30:0]           in_radius,
   output logic                  q_valid,
   input  logic                  q_ready,
   output logic [1:0]            q_opcode,
   output logic [3:0]            q_index,
   output logic [WORD_BITS-1:0]  q_value,
   output logic [31:0]           q_cx,
   output logic [31:0]           q_cy,
   output logic [31:0]           q_cz,
   output logic [30:0]           q_radius
);
   import fsc_pkg::*;

   localparam int QW = 2 + 4 + WORD_BITS + 32 * 3 + 31;

   logic [QW-1:0] slot_ff [2];
   logic          wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] sat_value;
   logic          push, pop;

   // Sign-extend or saturate the element to the word width on entry.
   always_comb begin
      if (WORD_BITS >= 32) begin
         sat_value = WORD_BITS'($signed(in_value));
      end else if ($signed(in_value) > $signed(32'((64'd1 << (WORD_BITS - 1)) - 1))) begin
         sat_value = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if ($signed(in_value) < -$signed(32'(64'd1 << (WORD_BITS - 1)))) begin
         sat_value = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         sat_value = WORD_BITS'(in_value);
      end
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign wptr_in  = push ? ~wptr_ff : wptr_ff;
   assign rptr_in  = pop ? ~rptr_ff : rptr_ff;
   assign cnt_in   = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= {in_opcode, in_index, sat_value, in_cx, in_cy, in_cz, in_radius};
      end
   end

   assign {q_opcode, q_index, q_value, q_cx, q_cy, q_cz, q_radius} = slot_ff[rptr_ff];

endmodule

[rtl/fsc_back.sv]
module fsc_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [1:0]            q_opcode,
   input  logic [3:0]            q_index,
   input  logic [WORD_BITS-1:0]  q_value,
   input  logic [31:0]           q_cx,
   input  logic [31:0]           q_cy,
   input  logic [31:0]           q_cz,
   input  logic [30:0]           q_radius,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_visible,
   output logic                  out_planes_ready
);
   import fsc_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int MW  = (W > 32) ? W : 32;    // multiplier operand
   localparam int PW  = 2 * W + 2;            // product and sum of squares
   localparam int AW  = 2 * MW + FRAC_BITS + 4; // test accumulator
   localparam int RW  = ROOT_BITS;
   localparam int NW  = W + FRAC_BITS + 1;    // dividend bits
   localparam int DW  = ((W > 31) ? W : 31) + 2; // offset plus radius

   state_type state_ff, state_in;

   logic [W-1:0]  mat_ff [16];
   logic [W-1:0]  pl_ff [24];
   logic          rdy_ff;
   logic          vis_ff;
   logic          out_valid_ff;
   logic [1:0]    op_ff;
   logic [2:0]    pidx_ff;
   logic [1:0]    j_ff;
   logic [W-1:0]  raw_ff [4];
   logic [PW-1:0] sum_ff;
   logic [2*RW-1:0] root_ff;
   logic [2*RW-1:0] sqx_ff;
   logic [2*RW-1:0] sqone_ff;
   logic [6:0]    bit_ff;
   logic [NW-1:0] num_ff;
   logic [NW:0]   rem_ff;
   logic [NW-1:0] quo_ff;
   logic [6:0]    dcnt_ff;
   logic [AW-1:0] acc_ff;
   logic [31:0]   cx_ff, cy_ff, cz_ff;
   logic [30:0]   rad_ff;

   logic          accept;
   logic [1:0]    row_sel;
   logic          sub;
   logic signed [W:0] raw_sum;
   logic [W-1:0]  raw_sat;
   logic signed [MW-1:0] ma, mb;
   logic signed [2*MW-1:0] mprod;
   logic [2*RW:0] trial;
   logic [NW:0]   rem_sh;
   logic [W-1:0]  pv;
   logic [W-1:0]  mag;
   logic [NW-1:0] cap;
   logic [W-1:0]  qres;
   logic signed [DW-1:0] dr;

   assign accept = q_valid && q_ready;
   assign q_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_visible = vis_ff;
   assign out_planes_ready = rdy_ff;

   // Raw element: row 3 plus or minus the indexed row; plane 4 uses row 2.
   assign row_sel = 2'(pidx_ff >> 1);
   assign sub     = pidx_ff[0];
   always_comb begin
      logic signed [W:0] base, e;
      base = (pidx_ff == 3'd4) ? '0 : (W+1)'($signed(mat_ff[{j_ff, 2'd3}]));
      e    = (W+1)'($signed(mat_ff[{j_ff, row_sel}]));
      raw_sum = sub ? base - e : base + e;
      if (raw_sum[W] != raw_sum[W-1]) begin
         raw_sat = raw_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         raw_sat = raw_sum[W-1:0];
      end
   end

   // Shared signed multiplier: squares during build, plane times center in test.
   always_comb begin
      ma = MW'($signed(raw_ff[j_ff]));
      mb = MW'($signed(raw_ff[j_ff]));
      if (state_ff == ST_TEST) begin
         ma = MW'($signed(pl_ff[{pidx_ff, j_ff}]));
         unique case (j_ff)
            2'd0: mb = MW'($signed(cx_ff));
            2'd1: mb = MW'($signed(cy_ff));
            2'd2: mb = MW'($signed(cz_ff));
            default: mb = '0;
         endcase
      end
      mprod = ma * mb;
   end

   // Digit-by-digit square root: root_ff carries the partial root scaled by
   // the current bit weight, sqone_ff the square of that weight.
   assign trial = (2*RW+1)'(root_ff) + (2*RW+1)'(sqone_ff);

   assign pv  = raw_ff[j_ff];
   assign mag = pv[W-1] ? W'(-pv) : pv;
   assign cap = NW'((NW'(1) << (W - 1)) - (pv[W-1] ? NW'(0) : NW'(1)));
   assign rem_sh = {rem_ff[NW-1:0], num_ff[NW-1]};
   assign qres = pv[W-1] ? W'(-quo_ff) : W'(quo_ff);
   assign dr = DW'($signed(pl_ff[{pidx_ff, 2'd3}])) + DW'(rad_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            unique case (op_type'(q_opcode))
               OP_BUILD: state_in = ST_RAW;
               OP_TEST:  state_in = ST_TEST;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_RAW:  if (j_ff == 2'd3) state_in = ST_SQR;
         ST_SQR:  if (j_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT: if (sum_ff == '0) state_in = ST_DIV;
                  else if (bit_ff == 7'd0) state_in = ST_DIV;
         ST_DIV: begin
            if ((sum_ff == '0 || dcnt_ff == 7'd0) && j_ff == 2'd3) begin
               state_in = (pidx_ff == 3'(NUM_PLANES - 1)) ? ST_DONE : ST_RAW;
            end
         end
         ST_TEST: begin
            if (j_ff == 2'd3 && pidx_ff == 3'(NUM_PLANES - 1)) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdy_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         vis_ff       <= 1'b0;
         for (int i = 0; i < 24; i++) pl_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_DONE) begin
            out_valid_ff <= 1'b1;
            if (op_ff == OP_BUILD) rdy_ff <= 1'b1;
            if (op_ff == OP_LOAD) rdy_ff <= 1'b0;
            if (op_ff != OP_TEST) vis_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && accept) vis_ff <= 1'b1;
         if (state_ff == ST_TEST && j_ff == 2'd3 && $signed(acc_ff + AW'($signed(dr) <<<
             FRAC_BITS)) < 0) begin
            vis_ff <= 1'b0;
         end
         if (state_ff == ST_DIV) begin
            if (sum_ff == '0) pl_ff[{pidx_ff, j_ff}] <= pv;
            else if (dcnt_ff == 7'd0) pl_ff[{pidx_ff, j_ff}] <= qres;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            op_ff   <= q_opcode;
            pidx_ff <= '0;
            j_ff    <= '0;
            acc_ff  <= '0;
            cx_ff <= q_cx; cy_ff <= q_cy; cz_ff <= q_cz; rad_ff <= q_radius;
            if (accept && q_opcode == OP_LOAD) mat_ff[q_index] <= q_value;
         end
         ST_RAW: begin
            raw_ff[j_ff] <= raw_sat;
            j_ff   <= (j_ff == 2'd3) ? 2'd0 : 2'(j_ff + 1);
            sum_ff <= '0;
         end
         ST_SQR: begin
            sum_ff   <= sum_ff + PW'(mprod);
            sqx_ff   <= (2*RW)'(sum_ff + PW'(mprod));
            j_ff     <= (j_ff == 2'd2) ? 2'd0 : 2'(j_ff + 1);
            root_ff  <= '0;
            sqone_ff <= (2*RW)'(1) << (2 * (RW - 1));
            bit_ff   <= 7'(RW - 1);
         end
         ST_ROOT: begin
            if ((2*RW+1)'(sqx_ff) >= trial) begin
               sqx_ff  <= sqx_ff - trial[2*RW-1:0];
               root_ff <= (root_ff >> 1) + sqone_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            sqone_ff <= sqone_ff >> 2;
            bit_ff  <= 7'(bit_ff - 1);
            num_ff  <= NW'(mag) << FRAC_BITS;
            rem_ff  <= '0;
            quo_ff  <= '0;
            dcnt_ff <= 7'(NW);
         end
         ST_DIV: begin
            if (sum_ff == '0) begin
               j_ff <= 2'(j_ff + 1);
               if (j_ff == 2'd3) pidx_ff <= 3'(pidx_ff + 1);
            end else if (dcnt_ff != 7'd0) begin
               if (rem_sh >= (NW+1)'(root_ff)) begin
                  rem_ff <= rem_sh - (NW+1)'(root_ff);
                  quo_ff <= ({quo_ff[NW-2:0], 1'b1} > cap) ? cap : {quo_ff[NW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= ({quo_ff[NW-2:0], 1'b0} > cap) ? cap : {quo_ff[NW-2:0], 1'b0};
               end
               num_ff  <= num_ff << 1;
               dcnt_ff <= 7'(dcnt_ff - 1);
            end else begin
               j_ff    <= 2'(j_ff + 1);
               num_ff  <= NW'(raw_ff[2'(j_ff + 1)][W-1] ? W'(-raw_ff[2'(j_ff + 1)])
                          : raw_ff[2'(j_ff + 1)]) << FRAC_BITS;
               rem_ff  <= '0;
               quo_ff  <= '0;
               dcnt_ff <= 7'(NW);
               if (j_ff == 2'd3) pidx_ff <= 3'(pidx_ff + 1);
            end
         end
         ST_TEST: begin
            if (j_ff == 2'd3) begin
               acc_ff  <= '0;
               pidx_ff <= 3'(pidx_ff + 1);
            end else begin
               acc_ff <= acc_ff + AW'($signed(mprod));
            end
            j_ff <= 2'(j_ff + 1);
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/frustum_sphere_cull.sv]
// Frustum sphere culling block.
// One request channel (req_) carries a word with an opcode: load one matrix
// element, build the six frustum planes, or test a sphere against them.
// Every request word yields exactly one response word on the rsp_ channel,
// carrying the visible bit (zero for loads and builds) and planes_ready.
// A two-entry queue sits between the front, which accepts request words,
// and the back, which executes them one at a time with a shared multiplier.
// A load or an unused opcode goes from acceptance straight to its response.
// A test runs six planes, each through multiply-accumulate steps over the
// center and a compare against the radius. A build forms each plane's raw
// coefficients and their sum of squares, then runs a 50-step square root and
// a restoring divider per coefficient; a plane with a zero-length normal
// keeps its raw coefficients.
// The response register holds its word until rsp_ready is seen; while it is
// held the back stalls, and the front keeps accepting until the queue fills.
// Reset clears the planes to zero and clears planes_ready; the matrix is
// undefined until each element has been loaded.
module frustum_sphere_cull #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_elem_index,
   input  logic [31:0] req_elem_value,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [30:0] req_sphere_radius,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_visible,
   output logic        rsp_planes_ready
);
   import fsc_pkg::*;

   logic                 q_valid, q_ready;
   logic [1:0]           q_opcode;
   logic [3:0]           q_index;
   logic [WORD_BITS-1:0] q_value;
   logic [31:0]          q_cx, q_cy, q_cz;
   logic [30:0]          q_radius;

   fsc_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_opcode(req_opcode),
      .in_index(req_elem_index), .in_value(req_elem_value),
      .in_cx(req_center_x), .in_cy(req_center_y), .in_cz(req_center_z),
      .in_radius(req_sphere_radius),
      .q_valid, .q_ready, .q_opcode, .q_index, .q_value,
      .q_cx, .q_cy, .q_cz, .q_radius
   );

   fsc_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_opcode, .q_index, .q_value,
      .q_cx, .q_cy, .q_cz, .q_radius,
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_visible(rsp_visible), .out_planes_ready(rsp_planes_ready)
   );

endmodule

[rtl/fsc_checker.sv]
module fsc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible,
   input logic rsp_planes_ready
);

   // A stalled response word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible)
      && $stable(rsp_planes_ready))
      else $error("response word changed while stalled");

   // No response leaves the block in the cycle after reset.
   a_rst_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Handshake outputs are always known, and so is a presented response word.
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid})
      && (!rsp_valid || !$isunknown({rsp_visible, rsp_planes_ready})))
      else $error("unknown value on an output");

endmodule

bind frustum_sphere_cull fsc_checker u_fsc_checker (.*);
